/* rtl/hsgc_pkg.sv */
`default_nettype none
package hsgc_pkg;

	localparam int QW = 15;

	localparam logic [15:0] ONE_Q14 = 16'sd16384;
	localparam logic signed [18:0] PI_Q12 = 19'sd12868;
	localparam logic signed [18:0] TWO_PI_Q12 = 19'sd25736;
	localparam logic [13:0] MIN_SPAN = 14'd4;
	localparam logic signed [16:0] FWD_MARGIN = 17'sd12;
	localparam logic [16:0] MIN_BAND = 17'd26;

	localparam logic [2:0] ST_MOVING = 3'd0;
	localparam logic [2:0] ST_ACCEL = 3'd1;
	localparam logic [2:0] ST_DECEL = 3'd2;
	localparam logic [2:0] ST_STOPPED = 3'd3;

	typedef enum logic [2:0] {
		REG_TURN_SAT = 3'd0,
		REG_SHARP_TURN = 3'd1,
		REG_TURN_THR = 3'd2,
		REG_ATTACK_SPEED = 3'd3,
		REG_MIN_FRAC = 3'd4,
		REG_ACCEL_BAND = 3'd5
	} reg_idx_t;

endpackage
`default_nettype wire

/* rtl/hsgc_div.sv */
`default_nettype none
module hsgc_div #(
	parameter int NW = 28,
	parameter int DW = 14,
	parameter int SW = 1
) (
	input  wire logic                clk,
	input  wire logic                arst_n,
	input  wire logic                in_vld,
	input  wire logic [NW-1:0]       num,
	input  wire logic [DW-1:0]       den,
	input  wire logic                neg,
	input  wire logic [SW-1:0]       side,
	output logic                     out_vld,
	output logic signed [15:0]       quo,
	output logic [SW-1:0]            out_side
);
	import hsgc_pkg::*;

	localparam int TW = NW - QW;

	logic              vld_s  [0:QW];
	logic [DW-1:0]     rem_s  [0:QW];
	logic [QW-1:0]     low_s  [0:QW];
	logic [QW-1:0]     quo_s  [0:QW];
	logic [DW-1:0]     den_s  [0:QW];
	logic              ovf_s  [0:QW];
	logic              neg_s  [0:QW];
	logic [SW-1:0]     side_s [0:QW];

	logic [DW+TW-1:0] top_w;
	logic             ovf_w;
	logic [QW-1:0]    mag_w;

	assign top_w = {{DW{1'b0}}, num[NW-1:QW]};
	assign ovf_w = top_w >= {{TW{1'b0}}, den};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s[0] <= 1'b0;
		end else begin
			vld_s[0] <= in_vld;
		end
	end

	always_ff @(posedge clk) begin
		rem_s[0]  <= ovf_w ? '0 : top_w[DW-1:0];
		low_s[0]  <= num[QW-1:0];
		quo_s[0]  <= '0;
		den_s[0]  <= den;
		ovf_s[0]  <= ovf_w;
		neg_s[0]  <= neg;
		side_s[0] <= side;
	end

	for (genvar k = 0; k < QW; k++) begin : g_step
		logic [DW:0] r2;
		logic        ge;
		logic [DW:0] nr;

		assign r2 = {rem_s[k], low_s[k][QW-1]};
		assign ge = r2 >= {1'b0, den_s[k]};
		assign nr = ge ? (r2 - {1'b0, den_s[k]}) : r2;

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				vld_s[k+1] <= 1'b0;
			end else begin
				vld_s[k+1] <= vld_s[k];
			end
		end

		always_ff @(posedge clk) begin
			rem_s[k+1]  <= nr[DW-1:0];
			low_s[k+1]  <= {low_s[k][QW-2:0], 1'b0};
			quo_s[k+1]  <= {quo_s[k][QW-2:0], ge};
			den_s[k+1]  <= den_s[k];
			ovf_s[k+1]  <= ovf_s[k];
			neg_s[k+1]  <= neg_s[k];
			side_s[k+1] <= side_s[k];
		end
	end

	// saturate to one
	assign mag_w = (ovf_s[QW] || (quo_s[QW] > ONE_Q14[QW-1:0])) ? ONE_Q14[QW-1:0] : quo_s[QW];
	assign quo = neg_s[QW] ? -$signed({1'b0, mag_w}) : $signed({1'b0, mag_w});
	assign out_vld = vld_s[QW];
	assign out_side = side_s[QW];

endmodule
`default_nettype wire

/* rtl/heading_speed_guidance_controller.sv */
// Path to done: s1, s2, turn/frac dividers, s3 to s5, thr divider, done_q.
// Throughput: one word per cycle; busy stays low, start is taken every cycle.
// Two 16-stage restoring dividers (turn and throttle) set the depth.
// The receiver cannot stall; done is a one-cycle strobe.
// Reset: arst_n clears all valid bits and loads register defaults.
`default_nettype none
module heading_speed_guidance_controller (
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire logic               start,
	output logic                    busy,
	input  wire logic signed [15:0] desired_heading,
	input  wire logic signed [15:0] current_heading,
	input  wire logic [15:0]        current_speed,
	input  wire logic [2:0]         flight_state,
	output logic                    done,
	output logic signed [15:0]      throttle,
	output logic signed [15:0]      turn_rate,
	input  wire logic               cfg_valid,
	output logic                    cfg_ready,
	input  wire logic [2:0]         cfg_index,
	input  wire logic [15:0]        cfg_data
);
	import hsgc_pkg::*;

	logic [13:0] turn_sat_q, sharp_q, thr_q;
	logic [15:0] attack_q;
	logic [14:0] min_frac_q, band_q;

	assign cfg_ready = 1'b1;
	assign busy = 1'b0;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			turn_sat_q <= 14'd2048;
			sharp_q    <= 14'd4096;
			thr_q      <= 14'd1229;
			attack_q   <= 16'd2560;
			min_frac_q <= 15'd4915;
			band_q     <= 15'd3277;
		end else if (cfg_valid && cfg_ready) begin
			case (reg_idx_t'(cfg_index))
				REG_TURN_SAT:     turn_sat_q <= cfg_data[13:0];
				REG_SHARP_TURN:   sharp_q    <= cfg_data[13:0];
				REG_TURN_THR:     thr_q      <= cfg_data[13:0];
				REG_ATTACK_SPEED: attack_q   <= cfg_data;
				REG_MIN_FRAC:     min_frac_q <= cfg_data[14:0];
				REG_ACCEL_BAND:   band_q     <= cfg_data[14:0];
				default: ;
			endcase
		end
	end

	// s1: heading difference
	logic               vld_s1;
	logic signed [16:0] diff_s1;
	logic [15:0]        speed_s1;
	logic [2:0]         state_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
		end else begin
			vld_s1 <= start && !busy;
		end
	end

	always_ff @(posedge clk) begin
		diff_s1  <= 17'(desired_heading) - 17'(current_heading);
		speed_s1 <= current_speed;
		state_s1 <= flight_state;
	end

	// s2: wrap to [-pi, pi)
	logic signed [18:0] x_w, c_w;

	assign x_w = 19'(diff_s1) + PI_Q12;

	always_comb begin
		if (x_w >= 19'(3 * TWO_PI_Q12)) begin
			c_w = x_w - 19'(3 * TWO_PI_Q12);
		end else if (x_w >= 19'(2 * TWO_PI_Q12)) begin
			c_w = x_w - 19'(2 * TWO_PI_Q12);
		end else if (x_w >= TWO_PI_Q12) begin
			c_w = x_w - TWO_PI_Q12;
		end else if (x_w >= 19'sd0) begin
			c_w = x_w;
		end else if (x_w >= -TWO_PI_Q12) begin
			c_w = x_w + TWO_PI_Q12;
		end else if (x_w >= 19'(-2 * TWO_PI_Q12)) begin
			c_w = x_w + 19'(2 * TWO_PI_Q12);
		end else begin
			c_w = x_w + 19'(3 * TWO_PI_Q12);
		end
	end

	logic               vld_s2;
	logic signed [14:0] err_s2;
	logic [15:0]        speed_s2;
	logic [2:0]         state_s2;
	logic signed [18:0] err_w;

	assign err_w = c_w - PI_Q12;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s2 <= 1'b0;
		end else begin
			vld_s2 <= vld_s1;
		end
	end

	always_ff @(posedge clk) begin
		err_s2   <= err_w[14:0];
		speed_s2 <= speed_s1;
		state_s2 <= state_s1;
	end

	// divider operands
	logic [14:0]        aerr_w;
	logic               over_w;
	logic [13:0]        sat_w, span_w;
	logic signed [14:0] span_d_w;
	logic [27:0]        tnum_w, turn_num_w;
	logic [13:0]        tdiff_w;

	assign aerr_w     = err_s2[14] ? 15'(-err_s2) : 15'(err_s2);
	assign over_w     = aerr_w > {1'b0, thr_q};
	assign tdiff_w    = aerr_w[13:0] - thr_q;
	assign tnum_w     = over_w ? {tdiff_w, 14'd0} : '0;
	assign turn_num_w = {aerr_w[13:0], 14'd0};
	assign sat_w      = (turn_sat_q == '0) ? 14'd1 : turn_sat_q;
	assign span_d_w   = $signed({1'b0, sharp_q}) - $signed({1'b0, thr_q});
	assign span_w     = (span_d_w < $signed({1'b0, MIN_SPAN})) ? MIN_SPAN : span_d_w[13:0];

	logic               turn_vld, t_vld, turn_over;
	logic signed [15:0] turn_q, t_q;
	logic [18:0]        t_side;

	hsgc_div #(.NW(28), .DW(14), .SW(1)) u_turn_div (
		.clk(clk), .arst_n(arst_n), .in_vld(vld_s2), .num(turn_num_w), .den(sat_w),
		.neg(err_s2[14]), .side(over_w), .out_vld(turn_vld), .quo(turn_q),
		.out_side(turn_over)
	);

	hsgc_div #(.NW(28), .DW(14), .SW(19)) u_frac_div (
		.clk(clk), .arst_n(arst_n), .in_vld(vld_s2), .num(tnum_w), .den(span_w),
		.neg(1'b0), .side({speed_s2, state_s2}), .out_vld(t_vld), .quo(t_q),
		.out_side(t_side)
	);

	// s3: speed fraction
	logic [14:0] mf_w, inv_w, frac_w;
	logic [29:0] p_w;

	assign mf_w   = (min_frac_q > ONE_Q14[14:0]) ? ONE_Q14[14:0] : min_frac_q;
	assign inv_w  = ONE_Q14[14:0] - mf_w;
	assign p_w    = t_q[14:0] * inv_w;
	assign frac_w = turn_over ? (ONE_Q14[14:0] - p_w[28:14]) : ONE_Q14[14:0];

	logic               vld_s3;
	logic [14:0]        frac_s3;
	logic signed [15:0] turn_s3;
	logic [15:0]        speed_s3;
	logic [2:0]         state_s3;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s3 <= 1'b0;
		end else begin
			vld_s3 <= turn_vld && t_vld;
		end
	end

	always_ff @(posedge clk) begin
		frac_s3  <= frac_w;
		turn_s3  <= turn_q;
		speed_s3 <= t_side[18:3];
		state_s3 <= t_side[2:0];
	end

	// s4: target speed
	logic [30:0] tprod_w;
	logic [15:0] target_w;
	logic        mov3_w;

	assign mov3_w  = (state_s3 == ST_MOVING) || (state_s3 == ST_ACCEL);
	assign tprod_w = attack_q * frac_s3;

	always_comb begin
		if (mov3_w) begin
			target_w = tprod_w[29:14];
		end else if ((state_s3 == ST_DECEL) || (state_s3 == ST_STOPPED)) begin
			target_w = '0;
		end else begin
			target_w = speed_s3;
		end
	end

	logic               vld_s4;
	logic [15:0]        target_s4, speed_s4;
	logic [2:0]         state_s4;
	logic signed [15:0] turn_s4;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s4 <= 1'b0;
		end else begin
			vld_s4 <= vld_s3;
		end
	end

	always_ff @(posedge clk) begin
		target_s4 <= target_w;
		speed_s4  <= speed_s3;
		state_s4  <= state_s3;
		turn_s4   <= turn_s3;
	end

	// s5: speed error and band
	logic signed [16:0] serr_w;
	logic [30:0]        bprod_w;
	logic [16:0]        band_w;
	logic               mov4_w;

	assign mov4_w  = (state_s4 == ST_MOVING) || (state_s4 == ST_ACCEL);
	assign serr_w  = $signed({1'b0, target_s4}) - $signed({1'b0, speed_s4});
	assign bprod_w = speed_s4 * band_q;
	assign band_w  = (bprod_w[30:14] < MIN_BAND) ? MIN_BAND : bprod_w[30:14];

	logic               vld_s5, fwd_s5, dec_s5;
	logic signed [16:0] serr_s5;
	logic [16:0]        band_s5;
	logic signed [15:0] turn_s5;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s5 <= 1'b0;
		end else begin
			vld_s5 <= vld_s4;
		end
	end

	always_ff @(posedge clk) begin
		serr_s5 <= serr_w;
		band_s5 <= band_w;
		turn_s5 <= turn_s4;
		fwd_s5  <= mov4_w && (serr_w > FWD_MARGIN);
		dec_s5  <= state_s4 == ST_DECEL;
	end

	// throttle divider
	logic [16:0]        smag_w;
	logic [29:0]        snum_w;
	logic               thr_vld;
	logic signed [15:0] thr_q_w;
	logic [17:0]        thr_side;

	assign smag_w = serr_s5[16] ? 17'(-serr_s5) : 17'(serr_s5);
	assign snum_w = {smag_w[15:0], 14'd0};

	hsgc_div #(.NW(30), .DW(17), .SW(18)) u_thr_div (
		.clk(clk), .arst_n(arst_n), .in_vld(vld_s5), .num(snum_w), .den(band_s5),
		.neg(serr_s5[16]), .side({turn_s5, fwd_s5, dec_s5}), .out_vld(thr_vld),
		.quo(thr_q_w), .out_side(thr_side)
	);

	// output word
	logic               done_q;
	logic signed [15:0] throttle_q, turn_rate_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			done_q <= 1'b0;
		end else begin
			done_q <= thr_vld;
		end
	end

	always_ff @(posedge clk) begin
		turn_rate_q <= thr_side[17:2];
		if (thr_side[1]) begin
			throttle_q <= $signed(ONE_Q14);
		end else if (thr_side[0]) begin
			throttle_q <= -$signed(ONE_Q14);
		end else begin
			throttle_q <= thr_q_w;
		end
	end

	assign done      = done_q;
	assign throttle  = throttle_q;
	assign turn_rate = turn_rate_q;

endmodule
`default_nettype wire

/* rtl/hsgc_chk.sv */
`default_nettype none
module hsgc_chk (
	input wire logic               clk,
	input wire logic               arst_n,
	input wire logic               start,
	input wire logic               busy,
	input wire logic               done,
	input wire logic signed [15:0] throttle,
	input wire logic signed [15:0] turn_rate,
	input wire logic               cfg_valid,
	input wire logic               cfg_ready
);

	a_no_busy: assert property (@(posedge clk) disable iff (!arst_n) !busy)
		else $error("busy raised");

	a_done_lat: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> $past(start && !busy, 38))
		else $error("done without word accepted 38 cycles before");

	a_turn_rng: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> (turn_rate <= 16'sd16384) && (turn_rate >= -16'sd16384))
		else $error("turn_rate out of range");

	a_thr_rng: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> (throttle <= 16'sd16384) && (throttle >= -16'sd16384))
		else $error("throttle out of range");

	a_cfg_rdy: assert property (@(posedge clk) disable iff (!arst_n)
		cfg_valid |-> cfg_ready)
		else $error("config word not taken");

endmodule

bind heading_speed_guidance_controller hsgc_chk u_hsgc_chk (
	.clk(clk), .arst_n(arst_n), .start(start), .busy(busy), .done(done),
	.throttle(throttle), .turn_rate(turn_rate), .cfg_valid(cfg_valid),
	.cfg_ready(cfg_ready)
);
`default_nettype wire
